FILE: src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on clk and arst_n being present in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRRA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("frra assertion failed");
`define FRRA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("frra assertion failed");
`else
`define FRRA_ASSERT(lbl, prop)
`define FRRA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/frra_pkg.sv
// Types and constants for the free region range allocator.
// No dependencies.
package frra_pkg;
	localparam int MAX_RANGES = 256;
	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int ADDR_W = 64;
	localparam logic [ADDR_W-1:0] LOW_MEM_RESET = 64'h0000_0000_0010_0000;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] rbeg;
		logic [ADDR_W-1:0] rend;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic push;
		logic [CNT_W-1:0] occ;
	} cell_ctl_t;
endpackage

FILE: src/frra_cell.sv
// One table cell of the range chain: loads from its neighbor or the write bus.
// Depends on frra_pkg.
module frra_cell (
	input logic clk,
	input frra_pkg::cell_ctl_t ctl,
	input logic [frra_pkg::IDX_W-1:0] idx,
	input frra_pkg::entry_t nb,
	input frra_pkg::entry_t wr,
	output frra_pkg::entry_t q
);
	logic [frra_pkg::CNT_W-1:0] pos;
	logic wr_hit;

	assign pos = {1'b0, idx};
	assign wr_hit = ctl.push && ((ctl.pop && (pos == ctl.occ - 1'b1)) ||
		(!ctl.pop && (pos == ctl.occ)));

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			q <= wr;
		end else if (ctl.pop) begin
			q <= nb;
		end
	end
endmodule

FILE: src/frra_chain.sv
// Row of range cells forming a compacting queue with the head at cell zero.
// Depends on frra_pkg and frra_cell.
module frra_chain (
	input logic clk,
	input frra_pkg::cell_ctl_t ctl,
	input frra_pkg::entry_t wr,
	output frra_pkg::entry_t head
);
	frra_pkg::entry_t cells [frra_pkg::MAX_RANGES];

	for (genvar i = 0; i < frra_pkg::MAX_RANGES; i++) begin : g_cell
		frra_pkg::entry_t nb;
		if (i == frra_pkg::MAX_RANGES - 1) begin : g_last
			assign nb = cells[i];
		end else begin : g_mid
			assign nb = cells[i+1];
		end
		frra_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.idx(frra_pkg::IDX_W'(i)),
			.nb(nb),
			.wr(wr),
			.q(cells[i])
		);
	end

	assign head = cells[0];
endmodule

FILE: src/free_region_range_allocator.sv
// Top level of the free region range allocator: control, merge and fit logic.
// Depends on frra_pkg, frra_chain and assert_macros.svh.
//
// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    operation, range_base, length, alignment
// out       source     out_valid/out_stall  status, block_base, block_size
// cfg       sink       cfg_we               cfg_wdata (low memory limit)
//
// Each pass moves one table entry per cycle through the cell chain head,
// except in cycles that insert the new range or a split-off remainder.
// Reset empties the table and sets the low memory limit to 1 MiB.
// A new transaction is taken while a finished result waits on out_stall.
module free_region_range_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] operation,
	input logic [63:0] range_base,
	input logic [63:0] length,
	input logic [63:0] alignment,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [63:0] block_base,
	output logic [63:0] block_size,
	input logic cfg_we,
	input logic [63:0] cfg_wdata
);
	`include "assert_macros.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD = 3'd1;
	localparam logic [2:0] S_SUB = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SDRAIN = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;
	localparam logic [frra_pkg::CNT_W-1:0] FULL = frra_pkg::CNT_W'(frra_pkg::MAX_RANGES);

	logic [2:0] state_q;
	logic [63:0] limit_q, mask_q, size_q, fit_rb_q, b_s1, re_s1;
	logic [frra_pkg::CNT_W-1:0] count_q, occ_q, rem_q, outn_q;
	frra_pkg::entry_t a_q, pend_q, xtra_q, head, wr, cand;
	frra_pkg::cell_ctl_t ctl;
	logic ins_q, pend_v_q, xtra_v_q, fit_v_q, pass_q, v_s1, alloc_q;
	logic [1:0] stat_q;
	logic res_v_q;
	logic [1:0] res_stat_q;
	logic [63:0] res_base_q, res_size_q;

	logic have_orig, take_new, join_pend, hit, accept;
	logic [64:0] fit_sum, in_sum;
	logic [63:0] rbc, in_end;
	logic nov, covers, bad_req;

	function automatic logic [frra_pkg::CNT_W-1:0] CNT_W1(input logic b);
		return {{(frra_pkg::CNT_W-1){1'b0}}, b};
	endfunction

	frra_chain u_chain (.clk(clk), .ctl(ctl), .wr(wr), .head(head));

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign have_orig = rem_q != '0;
	assign take_new = !ins_q && (!have_orig || head.rbeg > a_q.rbeg);
	assign cand = take_new ? a_q : head;
	assign join_pend = pend_v_q && cand.rbeg <= pend_q.rend;

	assign fit_sum = {1'b0, b_s1} + {1'b0, mask_q};
	assign rbc = fit_sum[63:0] & ~mask_q;
	assign hit = v_s1 && !fit_sum[64] && rbc < re_s1 && (re_s1 - rbc) >= size_q;

	assign nov = a_q.rend <= head.rbeg || a_q.rbeg >= head.rend;
	assign covers = a_q.rbeg <= head.rbeg && a_q.rend >= head.rend;

	assign in_sum = {1'b0, range_base} + {1'b0, length};
	assign in_end = in_sum[64] ? '1 : in_sum[63:0];
	assign bad_req = length == '0 || alignment == '0 ||
		(alignment & (alignment - 64'd1)) != '0;

	always_comb begin
		ctl.pop = 1'b0;
		ctl.push = 1'b0;
		ctl.occ = occ_q;
		wr = head;
		unique case (state_q)
			S_ADD: begin
				if (!ins_q || have_orig) begin
					ctl.pop = !take_new;
					if (pend_v_q && !join_pend) begin
						ctl.push = 1'b1;
						wr = pend_q;
					end
				end else begin
					ctl.push = 1'b1;
					wr = pend_q;
				end
			end
			S_SUB: begin
				if (xtra_v_q) begin
					ctl.push = 1'b1;
					wr = xtra_q;
				end else if (have_orig) begin
					ctl.pop = 1'b1;
					priority if (nov) begin
						ctl.push = 1'b1;
					end else if (covers) begin
						ctl.push = 1'b0;
					end else if (a_q.rbeg <= head.rbeg) begin
						ctl.push = 1'b1;
						wr = '{rbeg: a_q.rend, rend: head.rend};
					end else if (a_q.rend >= head.rend) begin
						ctl.push = 1'b1;
						wr = '{rbeg: head.rbeg, rend: a_q.rbeg};
					end else if (count_q == FULL) begin
						ctl.push = 1'b1;
					end else begin
						ctl.push = 1'b1;
						wr = '{rbeg: head.rbeg, rend: a_q.rbeg};
					end
				end
			end
			S_SCAN: begin
				ctl.pop = have_orig;
				ctl.push = have_orig;
			end
			default: begin
				ctl.pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= frra_pkg::LOW_MEM_RESET;
			count_q <= '0;
			occ_q <= '0;
			rem_q <= '0;
			outn_q <= '0;
			ins_q <= 1'b0;
			pend_v_q <= 1'b0;
			xtra_v_q <= 1'b0;
			fit_v_q <= 1'b0;
			pass_q <= 1'b0;
			v_s1 <= 1'b0;
			alloc_q <= 1'b0;
			stat_q <= frra_pkg::ST_OK;
			res_v_q <= 1'b0;
			res_stat_q <= frra_pkg::ST_OK;
			res_base_q <= '0;
			res_size_q <= '0;
			a_q <= '0;
			pend_q <= '0;
			xtra_q <= '0;
			mask_q <= '0;
			size_q <= '0;
			fit_rb_q <= '0;
			b_s1 <= '0;
			re_s1 <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			occ_q <= occ_q - CNT_W1(ctl.pop) + CNT_W1(ctl.push);
			if (ctl.push) begin
				outn_q <= outn_q + 1'b1;
			end
			if (ctl.pop) begin
				rem_q <= rem_q - 1'b1;
			end
			if (res_v_q && !out_stall && state_q != S_FIN) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						a_q <= '{rbeg: range_base, rend: in_end};
						rem_q <= count_q;
						outn_q <= '0;
						ins_q <= 1'b0;
						pend_v_q <= 1'b0;
						xtra_v_q <= 1'b0;
						fit_v_q <= 1'b0;
						pass_q <= 1'b0;
						v_s1 <= 1'b0;
						alloc_q <= 1'b0;
						stat_q <= frra_pkg::ST_OK;
						size_q <= length;
						mask_q <= alignment - 64'd1;
						unique case (operation)
							frra_pkg::OP_ADD: begin
								if (in_end == range_base) begin
									state_q <= S_FIN;
								end else if (count_q == FULL) begin
									stat_q <= frra_pkg::ST_FULL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_ADD;
								end
							end
							frra_pkg::OP_SUB: begin
								state_q <= (in_end == range_base) ? S_FIN : S_SUB;
							end
							frra_pkg::OP_ALLOC: begin
								if (bad_req) begin
									stat_q <= frra_pkg::ST_FAIL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								stat_q <= frra_pkg::ST_FAIL;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ADD: begin
					if (!ins_q || have_orig) begin
						ins_q <= ins_q | take_new;
						if (join_pend) begin
							if (cand.rend > pend_q.rend) begin
								pend_q.rend <= cand.rend;
							end
						end else begin
							pend_q <= cand;
							pend_v_q <= 1'b1;
						end
					end else begin
						count_q <= outn_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_SUB: begin
					if (xtra_v_q) begin
						xtra_v_q <= 1'b0;
					end else if (have_orig) begin
						if (!nov && !covers && a_q.rbeg > head.rbeg && a_q.rend < head.rend) begin
							if (count_q == FULL) begin
								stat_q <= frra_pkg::ST_FULL;
							end else begin
								xtra_q <= '{rbeg: a_q.rend, rend: head.rend};
								xtra_v_q <= 1'b1;
							end
						end
					end else begin
						count_q <= outn_q;
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (hit && !fit_v_q) begin
						fit_v_q <= 1'b1;
						fit_rb_q <= rbc;
					end
					v_s1 <= have_orig;
					b_s1 <= (!pass_q && head.rbeg < limit_q) ? limit_q : head.rbeg;
					re_s1 <= head.rend;
					if (!have_orig) begin
						state_q <= S_SDRAIN;
					end
				end
				S_SDRAIN: begin
					v_s1 <= 1'b0;
					if (fit_v_q) begin
						a_q <= '{rbeg: fit_rb_q, rend: fit_rb_q + size_q};
						alloc_q <= 1'b1;
						rem_q <= count_q;
						outn_q <= '0;
						state_q <= S_SUB;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
						rem_q <= count_q;
						state_q <= S_SCAN;
					end else begin
						stat_q <= frra_pkg::ST_FAIL;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_v_q || !out_stall) begin
						res_v_q <= 1'b1;
						res_stat_q <= stat_q;
						res_base_q <= (alloc_q && stat_q == frra_pkg::ST_OK) ? fit_rb_q : '0;
						res_size_q <= (alloc_q && stat_q == frra_pkg::ST_OK) ? size_q : '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = res_v_q;
	assign status = res_stat_q;
	assign block_base = res_base_q;
	assign block_size = res_size_q;

	`FRRA_ASSERT(a_accept_busy, accept |=> state_q != S_IDLE)
	`FRRA_ASSERT(a_occ_bound, occ_q <= FULL)
	`FRRA_ASSERT(a_count_bound, count_q <= FULL)
	`FRRA_ASSERT(a_rem_in_queue, rem_q <= occ_q)
	`FRRA_ASSERT(a_base_only_ok, (out_valid && block_base != '0) |-> status == frra_pkg::ST_OK)
endmodule

FILE: tb/sv/free_region_range_allocator_tb.sv
// Testbench for free_region_range_allocator: random and directed add, subtract and
// allocate transactions checked against an internal free-range table predictor.
// Depends on frra_pkg and the allocator RTL.
module free_region_range_allocator_tb;

	localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int LIMIT_CYCLES = 4000000;

	typedef struct packed {
		logic [1:0] st;
		logic [63:0] bb;
		logic [63:0] bs;
	} alloc_result_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	class range_table_scoreboard;
		logic [63:0] rs[frra_pkg::MAX_RANGES];
		logic [63:0] rl[frra_pkg::MAX_RANGES];
		int cnt;
		logic [63:0] low_limit;
		alloc_result_t pending[$];
		int checked;

		function new();
			cnt = 0;
			low_limit = frra_pkg::LOW_MEM_RESET;
			checked = 0;
		endfunction

		function logic [63:0] clip(logic [63:0] b, logic [63:0] l);
			return (l > TOP - b) ? TOP : b + l;
		endfunction

		function void merge();
			int w;
			logic [63:0] pe, ce;
			w = 0;
			if (cnt == 0)
				return;
			for (int r = 1; r < cnt; r++) begin
				pe = rs[w] + rl[w];
				ce = rs[r] + rl[r];
				if (rs[r] <= pe) begin
					if (ce > pe)
						rl[w] = ce - rs[w];
				end else begin
					w++;
					rs[w] = rs[r];
					rl[w] = rl[r];
				end
			end
			cnt = w + 1;
		endfunction

		function logic [1:0] add(logic [63:0] b, logic [63:0] l);
			logic [63:0] e;
			int p;
			e = clip(b, l);
			p = 0;
			if (e == b)
				return frra_pkg::ST_OK;
			if (cnt >= frra_pkg::MAX_RANGES)
				return frra_pkg::ST_FULL;
			while (p < cnt && rs[p] <= b)
				p++;
			for (int k = cnt; k > p; k--) begin
				rs[k] = rs[k-1];
				rl[k] = rl[k-1];
			end
			rs[p] = b;
			rl[p] = e - b;
			cnt++;
			merge();
			return frra_pkg::ST_OK;
		endfunction

		function logic [1:0] sub(logic [63:0] sb, logic [63:0] l);
			logic [63:0] se, rb, re;
			int i;
			se = clip(sb, l);
			i = 0;
			if (se == sb)
				return frra_pkg::ST_OK;
			while (i < cnt) begin
				rb = rs[i];
				re = rb + rl[i];
				if (se <= rb || sb >= re) begin
					i++;
				end else if (sb <= rb && se >= re) begin
					for (int k = i; k < cnt - 1; k++) begin
						rs[k] = rs[k+1];
						rl[k] = rl[k+1];
					end
					cnt--;
				end else if (sb <= rb) begin
					rs[i] = se;
					rl[i] = re - se;
					i++;
				end else if (se >= re) begin
					rl[i] = sb - rb;
					i++;
				end else begin
					if (cnt >= frra_pkg::MAX_RANGES)
						return frra_pkg::ST_FULL;
					for (int k = cnt; k > i + 1; k--) begin
						rs[k] = rs[k-1];
						rl[k] = rl[k-1];
					end
					rs[i+1] = se;
					rl[i+1] = re - se;
					rl[i] = sb - rb;
					cnt++;
					return frra_pkg::ST_OK;
				end
			end
			return frra_pkg::ST_OK;
		endfunction

		function alloc_result_t alloc(logic [63:0] sz, logic [63:0] al);
			alloc_result_t r;
			logic [63:0] mask, b, re, ab;
			r = '0;
			r.st = frra_pkg::ST_FAIL;
			if (sz == 0 || al == 0 || (al & (al - 1)) != 0)
				return r;
			mask = al - 1;
			for (int ps = 0; ps < 2; ps++) begin
				for (int i = 0; i < cnt; i++) begin
					b = rs[i];
					re = b + rl[i];
					if (ps == 0 && b < low_limit)
						b = low_limit;
					if (b > TOP - mask)
						continue;
					ab = (b + mask) & ~mask;
					if (ab >= re)
						continue;
					if (re - ab < sz)
						continue;
					if (sub(ab, sz) != frra_pkg::ST_OK) begin
						r.st = frra_pkg::ST_FULL;
						return r;
					end
					r.st = frra_pkg::ST_OK;
					r.bb = ab;
					r.bs = sz;
					return r;
				end
			end
			return r;
		endfunction

		function void note_input(logic [1:0] op, logic [63:0] b, logic [63:0] l,
				logic [63:0] al);
			alloc_result_t r;
			r = '0;
			if (op == frra_pkg::OP_ADD)
				r.st = add(b, l);
			else if (op == frra_pkg::OP_SUB)
				r.st = sub(b, l);
			else if (op == frra_pkg::OP_ALLOC)
				r = alloc(l, al);
			else
				r.st = frra_pkg::ST_FAIL;
			pending.push_back(r);
		endfunction

		task check_result(logic [1:0] st, logic [63:0] bb, logic [63:0] bs);
			alloc_result_t e;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result status %0d", st));
				return;
			end
			e = pending.pop_front();
			if (st !== e.st)
				report($sformatf("status %0d, expected %0d", st, e.st));
			if (bb !== e.bb)
				report($sformatf("block_base %h, expected %h", bb, e.bb));
			if (bs !== e.bs)
				report($sformatf("block_size %h, expected %h", bs, e.bs));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [63:0] range_base = '0;
	logic [63:0] length = '0;
	logic [63:0] alignment = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [63:0] block_base;
	logic [63:0] block_size;
	logic cfg_we = 0;
	logic [63:0] cfg_wdata = '0;

	free_region_range_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .range_base(range_base), .length(length),
		.alignment(alignment),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .block_base(block_base), .block_size(block_size),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	range_table_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;
	int cycles = 0;
	int sent = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, block_base, block_size);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic send(input logic [1:0] op, input logic [63:0] b, input logic [63:0] l,
			input logic [63:0] al);
		while ($urandom_range(99) < send_idle)
			@(posedge clk);
		in_valid <= 1;
		operation <= op;
		range_base <= b;
		length <= l;
		alignment <= al;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(op, b, l, al);
		sent++;
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3 * frra_pkg::MAX_RANGES + 20)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [63:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.low_limit = v;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_addr();
		case ($urandom_range(9))
			0: return rnd64();
			1: return TOP - $urandom_range(4096);
			2: return {$urandom_range(3), 20'h0} + $urandom_range(65535);
			default: return {$urandom_range(255), 12'h0};
		endcase
	endfunction

	function automatic logic [63:0] pick_len();
		case ($urandom_range(9))
			0: return rnd64();
			1: return 0;
			2: return TOP;
			default: return {$urandom_range(64), 12'h0} + $urandom_range(3);
		endcase
	endfunction

	function automatic logic [63:0] pick_align();
		case ($urandom_range(9))
			0: return rnd64();
			1: return 0;
			default: return 64'd1 << $urandom_range($urandom_range(1) ? 63 : 14);
		endcase
	endfunction

	task automatic random_items(input int n, input int idle, input int stall);
		int k;
		send_idle = idle;
		recv_stall = stall;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 35)
				send(frra_pkg::OP_ADD, pick_addr(), pick_len(), rnd64());
			else if (k < 60)
				send(frra_pkg::OP_SUB, pick_addr(), pick_len(), rnd64());
			else if (k < 97)
				send(frra_pkg::OP_ALLOC, rnd64(), pick_len(), pick_align());
			else
				send(frra_pkg::OP_UNUSED, rnd64(), rnd64(), rnd64());
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every operation and the special cases.
		send(frra_pkg::OP_ALLOC, 0, 64'h1000, 64'h1000);
		send(frra_pkg::OP_ADD, 0, 0, 0);
		send(frra_pkg::OP_ADD, 64'h1000, 64'h10_0000, 0);
		send(frra_pkg::OP_ADD, TOP - 64'hFF, TOP, 0);
		send(frra_pkg::OP_ADD, 64'h10_1000, 64'h1000, 0);
		send(frra_pkg::OP_ALLOC, 0, 64'h100, 64'h100);
		send(frra_pkg::OP_ALLOC, 0, 64'h100, 0);
		send(frra_pkg::OP_ALLOC, 0, 0, 64'h10);
		send(frra_pkg::OP_ALLOC, 0, 64'h10, 64'h3);
		send(frra_pkg::OP_ALLOC, 0, 64'h10, 64'h8000_0000_0000_0000);
		send(frra_pkg::OP_ALLOC, 0, TOP, 64'h1);
		send(frra_pkg::OP_SUB, 64'h2000, 64'h1000, 0);
		send(frra_pkg::OP_SUB, 0, 64'h1800, 0);
		send(frra_pkg::OP_SUB, TOP - 64'h10, TOP, 0);
		send(frra_pkg::OP_SUB, 5, 0, 0);
		send(frra_pkg::OP_UNUSED, TOP, TOP, TOP);
		send(frra_pkg::OP_ALLOC, TOP, 64'h10, 64'h1);
		// Fill the table with disjoint ranges to reach the full cases.
		for (int i = 0; i < frra_pkg::MAX_RANGES; i++)
			send(frra_pkg::OP_ADD, 64'h100_0000 + i * 64'h100, 64'h80, 0);
		send(frra_pkg::OP_ADD, 64'h100_0000 + 64'h40, 64'h10, 0);
		send(frra_pkg::OP_SUB, 64'h100_0010, 64'h10, 0);
		send(frra_pkg::OP_ALLOC, 0, 64'h8, 64'h8);
		send(frra_pkg::OP_SUB, 0, TOP, 0);

		write_limit(0);
		random_items(180, 0, 0);
		write_limit(TOP);
		random_items(160, 72, 0);
		write_limit({$urandom_range(7), 20'h0});
		random_items(160, 0, 72);
		write_limit(64'h10_0000);
		random_items(160, 27, 27);
		// Long receiver hold-off while the sender keeps offering.
		hold_off = 400;
		random_items(50, 0, 0);
		write_limit(rnd64());
		random_items(180, 0, 0);

		drain();
		$display("Run covered %0d transactions and %0d checked results over several",
			sent, sb.checked);
		$display("low memory limit settings with varied idle and stall patterns.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/frra_pkg.sv
src/frra_cell.sv
src/frra_chain.sv
src/free_region_range_allocator.sv
tb/sv/free_region_range_allocator_tb.sv
